// File: hdl/twsdw_pkg.sv
package twsdw_pkg;

  // op field codes on the input channel
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_AUTO_INC   = 2'd0;
  localparam logic [1:0] REG_START_ADDR = 2'd1;
  localparam logic [1:0] REG_DISP_CTRL  = 2'd2;

  localparam logic [7:0] AUTO_INC_RESET   = 8'h40;
  localparam logic [7:0] START_ADDR_RESET = 8'hC0;
  localparam logic [7:0] DISP_CTRL_RESET  = 8'h88;

  // transfer numbers within one sequence
  localparam logic [1:0] XFER_CMD  = 2'd0;
  localparam logic [1:0] XFER_DATA = 2'd1;
  localparam logic [1:0] XFER_CTRL = 2'd2;

  localparam logic [2:0] LAST_BIT = 3'd7;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_START = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
    logic       sense;
  } beat_t;

  typedef struct packed {
    logic [7:0] auto_inc;
    logic [7:0] start_addr;
    logic [7:0] disp_ctrl;
  } cfg_t;

endpackage

// File: hdl/two_wire_segment_display_writer_top.sv
// A result beat passes the input register, the command queue and the sequencer
// output register before it is offered; a full queue or a stalled output holds it.
// Throughput: one beat per cycle while neither the queue nor the output stalls;
// the sequencer handles each queued beat as it pops it.
// Reset (rst, synchronous, active high) empties the queue, idles the sequencer,
// clears the byte count and restores the three command registers.
module two_wire_segment_display_writer_top #(
  parameter int unsigned MAX_BYTES     = 8,
  parameter int unsigned STRETCH_LIMIT = 20
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] op,
  input  logic [7:0] data_byte,
  input  logic       clock_sense,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       clock_drive,
  output logic       data_drive,
  output logic       busy_res,
  output logic       done_res,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  twsdw_pkg::cfg_t  cfg;
  twsdw_pkg::beat_t push_beat;
  twsdw_pkg::beat_t head;
  logic             push, q_full, q_empty, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.auto_inc   <= twsdw_pkg::AUTO_INC_RESET;
      cfg.start_addr <= twsdw_pkg::START_ADDR_RESET;
      cfg.disp_ctrl  <= twsdw_pkg::DISP_CTRL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        twsdw_pkg::REG_AUTO_INC:   cfg.auto_inc   <= cfg_data;
        twsdw_pkg::REG_START_ADDR: cfg.start_addr <= cfg_data;
        twsdw_pkg::REG_DISP_CTRL:  cfg.disp_ctrl  <= cfg_data;
        default: ;
      endcase
    end
  end

  twsdw_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .data_byte   (data_byte),
    .clock_sense (clock_sense),
    .push        (push),
    .push_beat   (push_beat),
    .q_full      (q_full)
  );

  twsdw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_beat (push_beat),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  twsdw_back #(
    .MAX_BYTES     (MAX_BYTES),
    .STRETCH_LIMIT (STRETCH_LIMIT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .empty       (q_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .clock_drive (clock_drive),
    .data_drive  (data_drive),
    .busy_res    (busy_res),
    .done_res    (done_res)
  );

endmodule

// File: hdl/twsdw_front.sv
module twsdw_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic [7:0]         data_byte,
  input  logic               clock_sense,
  output logic               push,
  output twsdw_pkg::beat_t   push_beat,
  input  logic               q_full
);

  logic             held;
  twsdw_pkg::beat_t beat;
  twsdw_pkg::cmd_t  cmd_dec;

  always_comb begin
    case (op)
      twsdw_pkg::OP_TICK:  cmd_dec = twsdw_pkg::CMD_TICK;
      twsdw_pkg::OP_LOAD:  cmd_dec = twsdw_pkg::CMD_LOAD;
      twsdw_pkg::OP_START: cmd_dec = twsdw_pkg::CMD_START;
      default:             cmd_dec = twsdw_pkg::CMD_NOP;
    endcase
  end

  assign push      = held && !q_full;
  assign push_beat = beat;
  assign in_ready  = !held || push;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        held       <= 1'b1;
        beat.cmd   <= cmd_dec;
        beat.data  <= data_byte;
        beat.sense <= clock_sense;
      end else if (push) begin
        held <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/twsdw_queue.sv
module twsdw_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  twsdw_pkg::beat_t push_beat,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output twsdw_pkg::beat_t head
);

  twsdw_pkg::beat_t                   slots [twsdw_pkg::QUEUE_DEPTH];
  logic [twsdw_pkg::QPTR_W-1:0]       wr_ptr;
  logic [twsdw_pkg::QPTR_W-1:0]       rd_ptr;
  logic [twsdw_pkg::QCNT_W-1:0]       fill;

  assign full  = (fill == twsdw_pkg::QCNT_W'(twsdw_pkg::QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: hdl/twsdw_back.sv
module twsdw_back #(
  parameter int unsigned MAX_BYTES     = 8,
  parameter int unsigned STRETCH_LIMIT = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  twsdw_pkg::cfg_t  cfg,
  input  logic             empty,
  input  twsdw_pkg::beat_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             clock_drive,
  output logic             data_drive,
  output logic             busy_res,
  output logic             done_res
);

  localparam int unsigned CNT_W = $clog2(MAX_BYTES + 1);
  localparam int unsigned IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int unsigned SC_W  = $clog2(STRETCH_LIMIT + 1);

  typedef enum logic [3:0] {
    PH_IDLE, PH_ST1, PH_ST2, PH_BIT, PH_BSTR, PH_ACK, PH_ASTR, PH_SP1, PH_SP2
  } phase_t;

  logic [7:0]       byte_buffer [MAX_BYTES];
  phase_t           phase, phase_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [CNT_W-1:0] send_index, send_index_next;
  logic [1:0]       transfer_number, transfer_number_next;
  logic [7:0]       shift_byte, shift_byte_next;
  logic [2:0]       bit_index, bit_index_next;
  logic [SC_W-1:0]  stretch_count, stretch_count_next;
  logic [1:0]       line_levels, line_levels_next;
  logic             load_en;
  logic             res_clock, res_data, res_busy, res_done;
  logic [7:0]       buf_head;
  logic             stretching;

  assign pop        = !empty && (!out_valid || out_ready);
  assign buf_head   = byte_buffer[send_index[IDX_W-1:0]];
  assign stretching = !head.sense && (stretch_count < SC_W'(STRETCH_LIMIT));

  always_comb begin
    phase_next           = phase;
    byte_count_next      = byte_count;
    send_index_next      = send_index;
    transfer_number_next = transfer_number;
    shift_byte_next      = shift_byte;
    bit_index_next       = bit_index;
    stretch_count_next   = stretch_count;
    line_levels_next     = line_levels;
    load_en              = 1'b0;
    res_done             = 1'b0;

    case (head.cmd)
      twsdw_pkg::CMD_LOAD: begin
        if (phase == PH_IDLE && byte_count < CNT_W'(MAX_BYTES)) begin
          load_en         = 1'b1;
          byte_count_next = byte_count + 1'b1;
        end
      end
      twsdw_pkg::CMD_START: begin
        if (phase == PH_IDLE) begin
          transfer_number_next = twsdw_pkg::XFER_CMD;
          send_index_next      = '0;
          phase_next           = PH_ST1;
        end
      end
      twsdw_pkg::CMD_TICK: begin
        case (phase)
          PH_IDLE: ;
          PH_ST1: begin
            line_levels_next = 2'b11;
            phase_next       = PH_ST2;
          end
          PH_ST2: begin
            line_levels_next = 2'b10;
            case (transfer_number)
              twsdw_pkg::XFER_CMD:  shift_byte_next = cfg.auto_inc;
              twsdw_pkg::XFER_DATA: shift_byte_next = cfg.start_addr;
              default:              shift_byte_next = cfg.disp_ctrl;
            endcase
            bit_index_next = '0;
            phase_next     = PH_BIT;
          end
          PH_BIT: begin
            line_levels_next   = {1'b1, shift_byte[0]};
            stretch_count_next = '0;
            phase_next         = PH_BSTR;
          end
          PH_BSTR: begin
            if (stretching) begin
              line_levels_next   = {1'b1, shift_byte[0]};
              stretch_count_next = stretch_count + 1'b1;
            end else begin
              // finish the bit and run the next phase in the same tick
              shift_byte_next    = {1'b0, shift_byte[7:1]};
              stretch_count_next = '0;
              if (bit_index >= twsdw_pkg::LAST_BIT) begin
                line_levels_next = 2'b01;
                phase_next       = PH_ASTR;
              end else begin
                bit_index_next   = bit_index + 1'b1;
                line_levels_next = {1'b1, shift_byte[1]};
                phase_next       = PH_BSTR;
              end
            end
          end
          PH_ACK: begin
            line_levels_next   = 2'b01;
            stretch_count_next = '0;
            phase_next         = PH_ASTR;
          end
          PH_ASTR: begin
            if (stretching) begin
              line_levels_next   = 2'b11;
              stretch_count_next = stretch_count + 1'b1;
            end else if (transfer_number == twsdw_pkg::XFER_DATA &&
                         send_index < byte_count) begin
              // next display byte, first bit goes out now
              shift_byte_next    = buf_head;
              send_index_next    = send_index + 1'b1;
              bit_index_next     = '0;
              line_levels_next   = {1'b1, buf_head[0]};
              stretch_count_next = '0;
              phase_next         = PH_BSTR;
            end else begin
              line_levels_next = 2'b00;
              phase_next       = PH_SP2;
            end
          end
          PH_SP1: begin
            line_levels_next = 2'b00;
            phase_next       = PH_SP2;
          end
          PH_SP2: begin
            line_levels_next = 2'b10;
            if (transfer_number >= twsdw_pkg::XFER_CTRL) begin
              res_done = 1'b1;
            end else begin
              transfer_number_next = transfer_number + 1'b1;
              phase_next           = PH_ST1;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
      default: ;
    endcase

    res_clock = line_levels_next[1];
    res_data  = line_levels_next[0];
    res_busy  = (phase_next != PH_IDLE);

    // end of sequence: release both lines and drop the frame
    if (res_done) begin
      phase_next           = PH_IDLE;
      transfer_number_next = twsdw_pkg::XFER_CMD;
      byte_count_next      = '0;
      send_index_next      = '0;
      line_levels_next     = 2'b11;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && load_en) begin
      byte_buffer[byte_count[IDX_W-1:0]] <= head.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      byte_count      <= '0;
      send_index      <= '0;
      transfer_number <= '0;
      shift_byte      <= '0;
      bit_index       <= '0;
      stretch_count   <= '0;
      line_levels     <= 2'b00;
      out_valid       <= 1'b0;
    end else begin
      if (pop) begin
        phase           <= phase_next;
        byte_count      <= byte_count_next;
        send_index      <= send_index_next;
        transfer_number <= transfer_number_next;
        shift_byte      <= shift_byte_next;
        bit_index       <= bit_index_next;
        stretch_count   <= stretch_count_next;
        line_levels     <= line_levels_next;
        out_valid       <= 1'b1;
        clock_drive     <= res_clock;
        data_drive      <= res_data;
        busy_res        <= res_busy;
        done_res        <= res_done;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/twsdw_checker.sv
module twsdw_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       clock_drive,
  input logic       data_drive,
  input logic       busy_res,
  input logic       done_res
);

  // a done beat closes a running sequence
  assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> busy_res)
    else $error("done beat without busy");

  // the final stop ends with clock high, data low
  assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> clock_drive && !data_drive)
    else $error("done beat not on stop level");

  // nothing is offered right after reset
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

  // hold a stalled result beat
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(clock_drive) &&
      $stable(data_drive) && $stable(busy_res) && $stable(done_res))
    else $error("stalled result beat changed");

endmodule

bind two_wire_segment_display_writer_top twsdw_checker u_twsdw_checker (.*);

// File: verif/tb_top.sv
module tb_top;

  localparam int BUF_DEPTH   = 8;
  localparam int STRETCH_MAX = 20;
  localparam int PIPE_LAT    = 2;
  localparam int RAND_BEATS  = 1100;
  localparam int CYCLE_LIMIT = 60000;

  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_START_HI, SEQ_START_LO, SEQ_BIT, SEQ_BIT_WAIT,
    SEQ_ACK, SEQ_ACK_WAIT, SEQ_STOP_LO, SEQ_STOP_HI
  } seq_phase_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic busy;
    logic done;
  } line_out_t;

  typedef enum logic [1:0] {ROW_BEAT, ROW_TICKS, ROW_FINISH, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    twsdw_pkg::cmd_t  cmd;
    logic [7:0]       data;
    logic             sense;
    logic [1:0]       reg_sel;
    logic [7:0]       reps;
    logic             typed;
    logic [3:0]       want;
  } row_t;

  // want is {clock, data, busy, done}
  localparam row_t DIRECTED [0:26] = '{
    '{ROW_BEAT, twsdw_pkg::CMD_TICK, 8'h00, 1'b1, 2'd0, 8'd0, 1'b1, 4'b0000},
    '{ROW_BEAT, twsdw_pkg::CMD_NOP, 8'hFF, 1'b0, 2'd0, 8'd0, 1'b1, 4'b0000},
    '{ROW_BEAT, twsdw_pkg::CMD_LOAD, 8'h00, 1'b1, 2'd0, 8'd0, 1'b1, 4'b0000},
    '{ROW_BEAT, twsdw_pkg::CMD_LOAD, 8'hFF, 1'b0, 2'd0, 8'd0, 1'b1, 4'b0000},
    '{ROW_BEAT, twsdw_pkg::CMD_LOAD, 8'h01, 1'b1, 2'd0, 8'd0, 1'b1, 4'b0000},
    '{ROW_BEAT, twsdw_pkg::CMD_LOAD, 8'h80, 1'b1, 2'd0, 8'd0, 1'b1, 4'b0000},
    '{ROW_BEAT, twsdw_pkg::CMD_LOAD, 8'h55, 1'b1, 2'd0, 8'd0, 1'b1, 4'b0000},
    '{ROW_BEAT, twsdw_pkg::CMD_LOAD, 8'hAA, 1'b1, 2'd0, 8'd0, 1'b1, 4'b0000},
    '{ROW_BEAT, twsdw_pkg::CMD_LOAD, 8'h7E, 1'b1, 2'd0, 8'd0, 1'b1, 4'b0000},
    '{ROW_BEAT, twsdw_pkg::CMD_LOAD, 8'h81, 1'b1, 2'd0, 8'd0, 1'b1, 4'b0000},
    // ninth load hits a full buffer
    '{ROW_BEAT, twsdw_pkg::CMD_LOAD, 8'h3C, 1'b1, 2'd0, 8'd0, 1'b1, 4'b0000},
    '{ROW_BEAT, twsdw_pkg::CMD_START, 8'h00, 1'b1, 2'd0, 8'd0, 1'b1, 4'b0010},
    '{ROW_BEAT, twsdw_pkg::CMD_LOAD, 8'hC3, 1'b1, 2'd0, 8'd0, 1'b1, 4'b0010},
    '{ROW_BEAT, twsdw_pkg::CMD_START, 8'h00, 1'b1, 2'd0, 8'd0, 1'b1, 4'b0010},
    '{ROW_BEAT, twsdw_pkg::CMD_TICK, 8'h00, 1'b1, 2'd0, 8'd0, 1'b1, 4'b1110},
    '{ROW_BEAT, twsdw_pkg::CMD_TICK, 8'h00, 1'b1, 2'd0, 8'd0, 1'b1, 4'b1010},
    '{ROW_BEAT, twsdw_pkg::CMD_TICK, 8'h00, 1'b1, 2'd0, 8'd0, 1'b1, 4'b1010},
    '{ROW_BEAT, twsdw_pkg::CMD_TICK, 8'h00, 1'b0, 2'd0, 8'd0, 1'b1, 4'b1010},
    // hold the clock low past the stretch limit
    '{ROW_TICKS, twsdw_pkg::CMD_TICK, 8'h00, 1'b0, 2'd0, 8'd25, 1'b0, 4'b0000},
    // control byte is picked up when its transfer begins
    '{ROW_CFG, twsdw_pkg::CMD_TICK, 8'h8F, 1'b1, twsdw_pkg::REG_DISP_CTRL,
      8'd0, 1'b0, 4'b0000},
    '{ROW_FINISH, twsdw_pkg::CMD_TICK, 8'h00, 1'b1, 2'd0, 8'd0, 1'b0, 4'b0000},
    '{ROW_BEAT, twsdw_pkg::CMD_TICK, 8'h00, 1'b1, 2'd0, 8'd0, 1'b1, 4'b1100},
    '{ROW_CFG, twsdw_pkg::CMD_TICK, 8'h00, 1'b1, twsdw_pkg::REG_AUTO_INC,
      8'd0, 1'b0, 4'b0000},
    '{ROW_CFG, twsdw_pkg::CMD_TICK, 8'hFF, 1'b1, twsdw_pkg::REG_START_ADDR,
      8'd0, 1'b0, 4'b0000},
    // buffer emptied by the last frame: address only
    '{ROW_BEAT, twsdw_pkg::CMD_START, 8'h00, 1'b1, 2'd0, 8'd0, 1'b1, 4'b1110},
    '{ROW_FINISH, twsdw_pkg::CMD_TICK, 8'h00, 1'b1, 2'd0, 8'd0, 1'b0, 4'b0000},
    '{ROW_BEAT, twsdw_pkg::CMD_TICK, 8'h00, 1'b0, 2'd0, 8'd0, 1'b1, 4'b1100}
  };

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [1:0] op          = twsdw_pkg::OP_TICK;
  logic [7:0] data_byte   = 8'h00;
  logic       clock_sense = 1'b1;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic       clock_drive;
  logic       data_drive;
  logic       busy_res;
  logic       done_res;
  logic       cfg_we      = 1'b0;
  logic [1:0] cfg_index   = twsdw_pkg::REG_AUTO_INC;
  logic [7:0] cfg_data    = 8'h00;

  two_wire_segment_display_writer_top dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // display sequencer shadow
  twsdw_pkg::cfg_t cfg_model = '{twsdw_pkg::AUTO_INC_RESET, twsdw_pkg::START_ADDR_RESET,
                                 twsdw_pkg::DISP_CTRL_RESET};
  logic [7:0] seg_bytes [0:BUF_DEPTH-1];
  int         seg_cnt    = 0;
  int         send_pos   = 0;
  seq_phase_t seq_ph     = SEQ_IDLE;
  logic [1:0] xfer_no    = twsdw_pkg::XFER_CMD;
  logic [7:0] shift_reg  = 8'h00;
  logic [2:0] bit_pos    = 3'd0;
  int         wait_cnt   = 0;
  logic [1:0] lines      = 2'b00;

  line_out_t  pending_lines [$];
  int send_idle_pct   = 12;
  int recv_idle_pct   = 66;
  int beats_sent      = 0;
  int useful_beats    = 0;
  int results_checked = 0;
  int frames_done     = 0;
  int cfg_writes      = 0;
  int mismatches      = 0;
  int cycle_cnt       = 0;

  function automatic line_out_t predict_display_step(twsdw_pkg::cmd_t cmd,
                                                     logic [7:0] data, logic sense);
    line_out_t res;
    bit emitted;
    bit done;
    emitted = 1'b0;
    done    = 1'b0;
    case (cmd)
      twsdw_pkg::CMD_LOAD: begin
        if (seq_ph == SEQ_IDLE && seg_cnt < BUF_DEPTH) begin
          seg_bytes[seg_cnt] = data;
          seg_cnt++;
        end
      end
      twsdw_pkg::CMD_START: begin
        if (seq_ph == SEQ_IDLE) begin
          xfer_no  = twsdw_pkg::XFER_CMD;
          send_pos = 0;
          seq_ph   = SEQ_START_HI;
        end
      end
      twsdw_pkg::CMD_TICK: begin
        // wait phases may fall through to the next phase within the same tick
        for (int step_try = 0; step_try < 3 && !emitted && seq_ph != SEQ_IDLE;
             step_try++) begin
          case (seq_ph)
            SEQ_START_HI: begin
              lines   = 2'b11;
              seq_ph  = SEQ_START_LO;
              emitted = 1'b1;
            end
            SEQ_START_LO: begin
              lines = 2'b10;
              case (xfer_no)
                twsdw_pkg::XFER_CMD:  shift_reg = cfg_model.auto_inc;
                twsdw_pkg::XFER_DATA: shift_reg = cfg_model.start_addr;
                default:              shift_reg = cfg_model.disp_ctrl;
              endcase
              bit_pos = 3'd0;
              seq_ph  = SEQ_BIT;
              emitted = 1'b1;
            end
            SEQ_BIT: begin
              lines    = {1'b1, shift_reg[0]};
              wait_cnt = 0;
              seq_ph   = SEQ_BIT_WAIT;
              emitted  = 1'b1;
            end
            SEQ_BIT_WAIT: begin
              if (!sense && wait_cnt < STRETCH_MAX) begin
                lines   = {1'b1, shift_reg[0]};
                wait_cnt++;
                emitted = 1'b1;
              end else begin
                shift_reg = shift_reg >> 1;
                if (bit_pos >= twsdw_pkg::LAST_BIT) begin
                  seq_ph = SEQ_ACK;
                end else begin
                  bit_pos++;
                  seq_ph = SEQ_BIT;
                end
              end
            end
            SEQ_ACK: begin
              lines    = 2'b01;
              wait_cnt = 0;
              seq_ph   = SEQ_ACK_WAIT;
              emitted  = 1'b1;
            end
            SEQ_ACK_WAIT: begin
              if (!sense && wait_cnt < STRETCH_MAX) begin
                lines   = 2'b11;
                wait_cnt++;
                emitted = 1'b1;
              end else if (xfer_no == twsdw_pkg::XFER_DATA && send_pos < seg_cnt) begin
                shift_reg = seg_bytes[send_pos];
                send_pos++;
                bit_pos = 3'd0;
                seq_ph  = SEQ_BIT;
              end else begin
                seq_ph = SEQ_STOP_LO;
              end
            end
            SEQ_STOP_LO: begin
              lines   = 2'b00;
              seq_ph  = SEQ_STOP_HI;
              emitted = 1'b1;
            end
            SEQ_STOP_HI: begin
              lines   = 2'b10;
              emitted = 1'b1;
              if (xfer_no == twsdw_pkg::XFER_CTRL) begin
                done = 1'b1;
              end else begin
                xfer_no++;
                seq_ph = SEQ_START_HI;
              end
            end
            default: begin
              seq_ph  = SEQ_IDLE;
              emitted = 1'b1;
            end
          endcase
        end
      end
      default: ;
    endcase
    res = '{scl: lines[1], sda: lines[0], busy: seq_ph != SEQ_IDLE, done: done};
    if (done) begin
      seq_ph   = SEQ_IDLE;
      xfer_no  = twsdw_pkg::XFER_CMD;
      seg_cnt  = 0;
      send_pos = 0;
      lines    = 2'b11;
      frames_done++;
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic send_beat(twsdw_pkg::cmd_t cmd, logic [7:0] data, logic sense,
                           bit typed = 1'b0, line_out_t want = '0);
    line_out_t got;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    op          <= cmd;
    data_byte   <= data;
    clock_sense <= sense;
    do @(posedge clk); while (!in_ready);
    got = predict_display_step(cmd, data, sense);
    pending_lines.push_back(typed ? want : got);
    beats_sent++;
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      twsdw_pkg::REG_AUTO_INC:   cfg_model.auto_inc   = val;
      twsdw_pkg::REG_START_ADDR: cfg_model.start_addr = val;
      twsdw_pkg::REG_DISP_CTRL:  cfg_model.disp_ctrl  = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // one load/start/tick frame with random content and some noise mixed in
  task automatic run_frame();
    int   n_loads;
    int   mode;
    int   low_left;
    int   pick;
    logic sense;
    pick = $urandom_range(19);
    if (pick < 2)      n_loads = 0;
    else if (pick < 4) n_loads = $urandom_range(BUF_DEPTH + 1, BUF_DEPTH + 3);
    else               n_loads = $urandom_range(1, BUF_DEPTH);
    pick = $urandom_range(9);
    mode = (pick < 5) ? 0 : (pick < 8) ? 1 : 2;
    low_left = 0;
    if ($urandom_range(7) == 0)
      send_beat(twsdw_pkg::CMD_TICK, 8'($urandom), 1'($urandom));
    if ($urandom_range(7) == 0)
      send_beat(twsdw_pkg::CMD_NOP, 8'($urandom), 1'($urandom));
    for (int i = 0; i < n_loads; i++) begin
      send_beat(twsdw_pkg::CMD_LOAD, 8'($urandom), 1'($urandom));
      if (i < BUF_DEPTH) useful_beats++;
    end
    send_beat(twsdw_pkg::CMD_START, 8'($urandom), 1'($urandom));
    useful_beats++;
    while (seq_ph != SEQ_IDLE) begin
      if ($urandom_range(29) == 0) begin
        // ignored while busy
        send_beat(twsdw_pkg::cmd_t'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
      end else begin
        case (mode)
          0: sense = 1'b1;
          1: sense = ($urandom_range(3) != 0);
          default: begin
            if (low_left == 0 && $urandom_range(19) == 0)
              low_left = $urandom_range(5, STRETCH_MAX + 4);
            sense = (low_left == 0);
            if (low_left > 0) low_left--;
          end
        endcase
        send_beat(twsdw_pkg::CMD_TICK, 8'($urandom), sense);
        useful_beats++;
      end
    end
  endtask

  always @(posedge clk) begin
    line_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_lines.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_lines.pop_front();
        if (clock_drive !== want.scl)
          report_mismatch($sformatf("beat %0d clock_drive %b, want %b",
                                    results_checked, clock_drive, want.scl));
        if (data_drive !== want.sda)
          report_mismatch($sformatf("beat %0d data_drive %b, want %b",
                                    results_checked, data_drive, want.sda));
        if (busy_res !== want.busy)
          report_mismatch($sformatf("beat %0d busy_res %b, want %b",
                                    results_checked, busy_res, want.busy));
        if (done_res !== want.done)
          report_mismatch($sformatf("beat %0d done_res %b, want %b",
                                    results_checked, done_res, want.done));
      end
      results_checked++;
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding",
               cycle_cnt, pending_lines.size());
      $display("two_wire_segment_display_writer_top verification failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      case (DIRECTED[i].kind)
        ROW_BEAT:
          send_beat(DIRECTED[i].cmd, DIRECTED[i].data, DIRECTED[i].sense,
                    DIRECTED[i].typed, line_out_t'(DIRECTED[i].want));
        ROW_TICKS:
          repeat (DIRECTED[i].reps)
            send_beat(twsdw_pkg::CMD_TICK, 8'h00, DIRECTED[i].sense);
        ROW_FINISH:
          while (seq_ph != SEQ_IDLE) send_beat(twsdw_pkg::CMD_TICK, 8'h00, 1'b1);
        default: begin
          drain_pipeline();
          write_reg(DIRECTED[i].reg_sel, DIRECTED[i].data);
        end
      endcase
    end

    for (int ph = 0; ph < 3; ph++) begin
      drain_pipeline();
      case (ph)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 66;
          write_reg(twsdw_pkg::REG_AUTO_INC, 8'($urandom));
          write_reg(twsdw_pkg::REG_START_ADDR, 8'($urandom));
          write_reg(twsdw_pkg::REG_DISP_CTRL, 8'($urandom));
        end
        1: begin
          send_idle_pct = 66;
          recv_idle_pct = 12;
          write_reg(twsdw_pkg::REG_AUTO_INC, 8'hFF);
          write_reg(twsdw_pkg::REG_START_ADDR, 8'h00);
          write_reg(twsdw_pkg::REG_DISP_CTRL, 8'h00);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_reg(twsdw_pkg::REG_AUTO_INC, 8'($urandom));
          write_reg(twsdw_pkg::REG_START_ADDR, 8'($urandom));
          write_reg(twsdw_pkg::REG_DISP_CTRL, 8'hFF);
        end
      endcase
      while (useful_beats < RAND_BEATS * (ph + 1) / 3) run_frame();
    end

    drain_pipeline();
    $display("%0d input beats sent, %0d result beats checked", beats_sent, results_checked);
    $display("%0d display frames completed over %0d register writes, %0d mismatches",
             frames_done, cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("two_wire_segment_display_writer_top verification clean");
    end else begin
      $display("two_wire_segment_display_writer_top verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/twsdw_pkg.sv
hdl/twsdw_front.sv
hdl/twsdw_queue.sv
hdl/twsdw_back.sv
hdl/two_wire_segment_display_writer_top.sv
hdl/twsdw_checker.sv
verif/tb_top.sv
